// File: src/slm_pkg.sv
// Shared types, constants and the bar weight table for the stereo level meter.
// Used by the channel interfaces and by the top-level module of the meter; no dependencies.
`default_nettype none

package slm_pkg;

    // bar count and derived sizes
    localparam int BARS   = 32;
    localparam int NBARS  = (BARS > 64) ? 64 : ((BARS < 1) ? 1 : BARS);
    localparam int BAR_AW = (NBARS > 1) ? $clog2(NBARS) : 1;

    localparam int DB_W  = 16;
    localparam int VAL_W = 17;
    localparam int IDX_W = 6;
    localparam int CNT_W = 8;
    localparam int REG_W = 3;

    localparam logic [VAL_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [35:0]      ROUND_HALF = 36'd32768;

    // dB to linear: x = db + 60 dB in Q8, lin = floor(x * 64 / 15)
    localparam logic signed [VAL_W-1:0] LIN_OFFSET = 17'sd15360;
    localparam logic [VAL_W:0]          LIN_RECIP  = 18'd17477;  // ceil(2^18 / 15)

    // register indexes
    localparam logic [REG_W-1:0] REG_SMOOTH_COEFF  = 3'd0;
    localparam logic [REG_W-1:0] REG_HOLD_FRAMES   = 3'd1;
    localparam logic [REG_W-1:0] REG_DECAY_STEP    = 3'd2;
    localparam logic [REG_W-1:0] REG_ATTACK_COEFF  = 3'd3;
    localparam logic [REG_W-1:0] REG_RELEASE_COEFF = 3'd4;

    localparam logic [VAL_W-1:0] SMOOTH_COEFF_RST  = 17'd9830;
    localparam logic [CNT_W-1:0] HOLD_FRAMES_RST   = 8'd45;
    localparam logic [VAL_W-1:0] DECAY_STEP_RST    = 17'd786;
    localparam logic [VAL_W-1:0] ATTACK_COEFF_RST  = 17'd26214;
    localparam logic [VAL_W-1:0] RELEASE_COEFF_RST = 17'd5243;

    localparam longint unsigned PI_Q52 = 64'd14148475504056880;

    typedef logic [VAL_W-1:0] weight_tab_t [NBARS];

    // coefficients above one act as one
    function automatic logic [VAL_W-1:0] coef_clamp(input logic [VAL_W-1:0] c);
        return (c > ONE_Q16) ? ONE_Q16 : c;
    endfunction

    // shift-subtract quotient or remainder, only evaluated while the weight table is built
    function automatic longint unsigned const_udiv(input longint unsigned num,
                                                   input longint unsigned den,
                                                   input bit              rem_only);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return rem_only ? r : q;
    endfunction

    // exp(-2.5*b/(BARS-1)) in Q30: Q28 series of exp(x/8), squared three times, inverted
    function automatic longint unsigned exp_term_q30(input int unsigned b);
        longint unsigned den;
        longint unsigned y;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned e;
        den  = (BARS > 1) ? 64'(BARS - 1) : 64'd1;
        y    = const_udiv((64'd5 * 64'(b)) << 28, 64'd16 * den, 1'b0);
        sum  = 64'd1 << 28;
        term = 64'd1 << 28;
        for (int k = 1; k <= 12; k++) begin
            term = const_udiv((term * y) >> 28, 64'(k), 1'b0);
            sum  = sum + term;
        end
        e = sum;
        for (int i = 0; i < 3; i++) begin
            e = (e * e) >> 28;
        end
        return const_udiv((64'd1 << 58) + (e >> 1), e, 1'b0);
    endfunction

    // |sin(n)| in Q30: reduce modulo pi in Q52, odd Taylor series
    function automatic longint unsigned abs_sin_q30(input int unsigned n);
        longint unsigned r;
        longint unsigned r2;
        longint unsigned t;
        longint unsigned pos;
        longint unsigned neg;
        r = const_udiv(64'(n) << 52, PI_Q52, 1'b1);
        if (r > (PI_Q52 >> 1)) begin
            r = PI_Q52 - r;
        end
        r   = r >> 22;
        r2  = (r * r) >> 30;
        t   = r;
        pos = 64'd0;
        neg = 64'd0;
        for (int k = 1; k <= 10; k++) begin
            if ((k & 1) == 1) begin
                pos = pos + t;
            end else begin
                neg = neg + t;
            end
            t = const_udiv((t * r2) >> 30, 64'(2 * k) * 64'(2 * k + 1), 1'b0);
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    function automatic weight_tab_t build_weights();
        weight_tab_t     w;
        longint unsigned var_q30;
        longint unsigned p;
        for (int b = 0; b < NBARS; b++) begin
            var_q30 = const_udiv((64'd4 << 30) + 64'd2 * abs_sin_q30(7 * b + 3), 64'd5, 1'b0);
            p       = exp_term_q30(b) * var_q30;
            w[b]    = VAL_W'((p + (64'd1 << 43)) >> 44);
        end
        return w;
    endfunction

    localparam weight_tab_t BAR_WEIGHT = build_weights();

endpackage

`default_nettype wire

// File: src/slm_in_if.sv
// Frame input channel: valid/ready handshake with four dB levels.
// Depends on slm_pkg for field widths.
`default_nettype none

interface slm_in_if import slm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [DB_W-1:0] peak_db_left;
    logic signed [DB_W-1:0] peak_db_right;
    logic signed [DB_W-1:0] rms_db_left;
    logic signed [DB_W-1:0] rms_db_right;

    modport source (
        output valid, peak_db_left, peak_db_right, rms_db_left, rms_db_right,
        input  ready
    );
    modport sink (
        input  valid, peak_db_left, peak_db_right, rms_db_left, rms_db_right,
        output ready
    );
endinterface

`default_nettype wire

// File: src/slm_out_if.sv
// Meter result channel: one transaction per bar, with the channel meters.
// Depends on slm_pkg for field widths.
`default_nettype none

interface slm_out_if import slm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bar_index;
    logic [VAL_W-1:0] bar_level;
    logic [VAL_W-1:0] smooth_peak_left;
    logic [VAL_W-1:0] smooth_peak_right;
    logic [VAL_W-1:0] smooth_rms_left;
    logic [VAL_W-1:0] smooth_rms_right;
    logic [VAL_W-1:0] hold_left;
    logic [VAL_W-1:0] hold_right;
    logic [VAL_W-1:0] mean_rms;
    logic             last_bar;

    modport source (
        output valid, bar_index, bar_level, smooth_peak_left, smooth_peak_right,
               smooth_rms_left, smooth_rms_right, hold_left, hold_right,
               mean_rms, last_bar,
        input  ready
    );
    modport sink (
        input  valid, bar_index, bar_level, smooth_peak_left, smooth_peak_right,
               smooth_rms_left, smooth_rms_right, hold_left, hold_right,
               mean_rms, last_bar,
        output ready
    );
endinterface

`default_nettype wire

// File: src/slm_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on slm_pkg for field widths.
`default_nettype none

interface slm_cfg_if import slm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REG_W-1:0] index;
    logic [VAL_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/stereo_level_meter_ballistics.sv
// Stereo level meter top level: register file, sequencer and shared multiplier.
// Depends on slm_pkg, slm_in_if, slm_out_if, slm_cfg_if and slm_ram.
// Sequence: after a frame transaction come four dB conversions, four smoothing updates and
// the hold update, then the bars in order, each waiting while the output register is full;
// all products go through one 18x18 multiplier, two per bar. A new frame is accepted only
// once the last bar of the previous frame has been issued.
// Reset: registers take their defaults; smoothed levels, holds and bar levels read as zero at once.
`default_nettype none

module stereo_level_meter_ballistics import slm_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    slm_cfg_if.sink  cfg,
    slm_in_if.sink   frame,
    slm_out_if.source meter
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LIN_MUL  = 4'd1;
    localparam logic [3:0] ST_LIN_FIN  = 4'd2;
    localparam logic [3:0] ST_SM_MUL1  = 4'd3;
    localparam logic [3:0] ST_SM_MUL2  = 4'd4;
    localparam logic [3:0] ST_SM_FIN   = 4'd5;
    localparam logic [3:0] ST_HOLD     = 4'd6;
    localparam logic [3:0] ST_BAR_MUL1 = 4'd7;
    localparam logic [3:0] ST_BAR_MUL2 = 4'd8;
    localparam logic [3:0] ST_BAR_FIN  = 4'd9;

    // registers
    logic [VAL_W-1:0] smooth_coeff_reg, decay_step_reg, attack_coeff_reg, release_coeff_reg;
    logic [CNT_W-1:0] hold_frames_reg;

    // sequencer
    logic [3:0]        state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [BAR_AW-1:0] bar_reg, bar_next;

    // meter state: index 0 peak left, 1 peak right, 2 rms left, 3 rms right
    logic signed [DB_W-1:0] db_reg [4];
    logic signed [DB_W-1:0] db_next [4];
    logic [VAL_W-1:0] lin_reg [4];
    logic [VAL_W-1:0] lin_next [4];
    logic [VAL_W-1:0] sm_reg [4];
    logic [VAL_W-1:0] sm_next [4];
    logic [VAL_W-1:0] hold_reg [2];
    logic [VAL_W-1:0] hold_next [2];
    logic [CNT_W-1:0] hcnt_reg [2];
    logic [CNT_W-1:0] hcnt_next [2];
    logic [NBARS-1:0] bar_valid_reg, bar_valid_next;

    // datapath
    logic [VAL_W-1:0] base_reg, base_next;
    logic [35:0]      prod_reg, prod_next;
    logic [35:0]      acc_reg, acc_next;
    logic             up_reg, up_next;
    logic [VAL_W-1:0] level_reg, level_next;
    logic             prod_en;
    logic [17:0]      mul_a, mul_b;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic [VAL_W-1:0] out_level_reg, out_level_next;
    logic [VAL_W-1:0] out_psl_reg, out_psl_next, out_psr_reg, out_psr_next;
    logic [VAL_W-1:0] out_rsl_reg, out_rsl_next, out_rsr_reg, out_rsr_next;
    logic [VAL_W-1:0] out_hl_reg, out_hl_next, out_hr_reg, out_hr_next;
    logic [VAL_W-1:0] out_mean_reg, out_mean_next;
    logic             out_last_reg, out_last_next;

    // combinational helpers
    logic [VAL_W-1:0]        c_smooth, c_attack, c_release;
    logic signed [VAL_W-1:0] lin_x;
    logic [9:0]              lin_q;
    logic [13:0]             lin_r14;
    logic [VAL_W-1:0]        lin_val;
    logic [35:0]             sm_sum;
    logic [35:0]             rnd_sum;
    logic [17:0]             rnd_val;
    logic [VAL_W-1:0]        ram_rdata;
    logic [VAL_W-1:0]        cur_level;
    logic                    tgt_up;
    logic [17:0]             tgt_diff;
    logic [18:0]             lv_raw;
    logic [VAL_W-1:0]        lv_new;
    logic                    out_free;
    logic                    ram_we;
    logic                    last_bar_now;

    function automatic logic [5:0] lin_frac(input logic [3:0] r);
        logic [5:0] f;
        unique case (r)
            4'd0:    f = 6'd0;
            4'd1:    f = 6'd4;
            4'd2:    f = 6'd8;
            4'd3:    f = 6'd12;
            4'd4:    f = 6'd17;
            4'd5:    f = 6'd21;
            4'd6:    f = 6'd25;
            4'd7:    f = 6'd29;
            4'd8:    f = 6'd34;
            4'd9:    f = 6'd38;
            4'd10:   f = 6'd42;
            4'd11:   f = 6'd46;
            4'd12:   f = 6'd51;
            4'd13:   f = 6'd55;
            4'd14:   f = 6'd59;
            default: f = 6'd0;
        endcase
        return f;
    endfunction

    assign cfg.ready   = 1'b1;
    assign frame.ready = (state_reg == ST_IDLE);

    assign c_smooth  = coef_clamp(smooth_coeff_reg);
    assign c_attack  = coef_clamp(attack_coeff_reg);
    assign c_release = coef_clamp(release_coeff_reg);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_coeff_reg  <= SMOOTH_COEFF_RST;
            hold_frames_reg   <= HOLD_FRAMES_RST;
            decay_step_reg    <= DECAY_STEP_RST;
            attack_coeff_reg  <= ATTACK_COEFF_RST;
            release_coeff_reg <= RELEASE_COEFF_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SMOOTH_COEFF:  smooth_coeff_reg  <= cfg.data;
                REG_HOLD_FRAMES:   hold_frames_reg   <= cfg.data[CNT_W-1:0];
                REG_DECAY_STEP:    decay_step_reg    <= cfg.data;
                REG_ATTACK_COEFF:  attack_coeff_reg  <= cfg.data;
                REG_RELEASE_COEFF: release_coeff_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // dB to linear from the latched level; quotient by 15 comes from the multiplier
    assign lin_x   = VAL_W'(db_reg[step_reg]) + LIN_OFFSET;
    assign lin_q   = prod_reg[27:18];
    assign lin_r14 = lin_x[13:0] - ({lin_q, 4'b0000} - {4'b0000, lin_q});

    always_comb
    begin
        if (lin_x <= 0)
        begin
            lin_val = '0;
        end
        else if (lin_x >= LIN_OFFSET)
        begin
            lin_val = ONE_Q16;
        end
        else
        begin
            lin_val = VAL_W'({lin_q, 6'b000000}) + VAL_W'(lin_frac(lin_r14[3:0]));
        end
    end

    // rounded Q16 results
    assign sm_sum  = acc_reg + prod_reg + ROUND_HALF;
    assign rnd_sum = prod_reg + ROUND_HALF;
    assign rnd_val = rnd_sum[33:16];

    // bar update: rnd_val is the target in BAR_MUL2 and the step in BAR_FIN
    assign cur_level = bar_valid_reg[bar_reg] ? ram_rdata : '0;
    assign tgt_up    = rnd_val > {1'b0, cur_level};
    assign tgt_diff  = tgt_up ? (rnd_val - {1'b0, cur_level}) : ({1'b0, cur_level} - rnd_val);

    always_comb
    begin
        if (up_reg)
        begin
            lv_raw = 19'(level_reg) + 19'(rnd_val);
        end
        else if (rnd_val > {1'b0, level_reg})
        begin
            lv_raw = '0;
        end
        else
        begin
            lv_raw = 19'(level_reg) - 19'(rnd_val);
        end
        lv_new = (lv_raw > 19'(ONE_Q16)) ? ONE_Q16 : lv_raw[VAL_W-1:0];
    end

    assign out_free     = !out_valid_reg || meter.ready;
    assign last_bar_now = (bar_reg == BAR_AW'(NBARS - 1));
    assign ram_we       = (state_reg == ST_BAR_FIN) && out_free;

    // shared multiplier operands
    always_comb
    begin
        prod_en = 1'b1;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_LIN_MUL:
            begin
                mul_a = {4'b0000, lin_x[13:0]};
                mul_b = LIN_RECIP;
            end
            ST_SM_MUL1:
            begin
                mul_a = {1'b0, sm_reg[step_reg]};
                mul_b = {1'b0, ONE_Q16 - c_smooth};
            end
            ST_SM_MUL2:
            begin
                mul_a = {1'b0, lin_reg[step_reg]};
                mul_b = {1'b0, c_smooth};
            end
            ST_BAR_MUL1:
            begin
                mul_a = {1'b0, base_reg};
                mul_b = {1'b0, BAR_WEIGHT[bar_reg]};
            end
            ST_BAR_MUL2:
            begin
                mul_a = tgt_diff;
                mul_b = {1'b0, tgt_up ? c_attack : c_release};
            end
            default:
            begin
                prod_en = 1'b0;
            end
        endcase
        prod_next = prod_en ? (mul_a * mul_b) : prod_reg;
    end

    // sequencer and state updates
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        bar_next       = bar_reg;
        db_next        = db_reg;
        lin_next       = lin_reg;
        sm_next        = sm_reg;
        hold_next      = hold_reg;
        hcnt_next      = hcnt_reg;
        bar_valid_next = bar_valid_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        up_next        = up_reg;
        level_next     = level_reg;

        out_valid_next = out_valid_reg && !meter.ready;
        out_index_next = out_index_reg;
        out_level_next = out_level_reg;
        out_psl_next   = out_psl_reg;
        out_psr_next   = out_psr_reg;
        out_rsl_next   = out_rsl_reg;
        out_rsr_next   = out_rsr_reg;
        out_hl_next    = out_hl_reg;
        out_hr_next    = out_hr_reg;
        out_mean_next  = out_mean_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame.valid)
                begin
                    db_next[0] = frame.peak_db_left;
                    db_next[1] = frame.peak_db_right;
                    db_next[2] = frame.rms_db_left;
                    db_next[3] = frame.rms_db_right;
                    step_next  = '0;
                    state_next = ST_LIN_MUL;
                end
            end
            ST_LIN_MUL:
            begin
                state_next = ST_LIN_FIN;
            end
            ST_LIN_FIN:
            begin
                lin_next[step_reg] = lin_val;
                step_next          = step_reg + 2'd1;
                state_next         = (step_reg == 2'd3) ? ST_SM_MUL1 : ST_LIN_MUL;
            end
            ST_SM_MUL1:
            begin
                state_next = ST_SM_MUL2;
            end
            ST_SM_MUL2:
            begin
                acc_next   = prod_reg;
                state_next = ST_SM_FIN;
            end
            ST_SM_FIN:
            begin
                sm_next[step_reg] = sm_sum[32:16];
                step_next         = step_reg + 2'd1;
                state_next        = (step_reg == 2'd3) ? ST_HOLD : ST_SM_MUL1;
            end
            ST_HOLD:
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    if (lin_reg[ch] >= hold_reg[ch])
                    begin
                        hold_next[ch] = lin_reg[ch];
                        hcnt_next[ch] = hold_frames_reg;
                    end
                    else if (hcnt_reg[ch] != '0)
                    begin
                        hcnt_next[ch] = hcnt_reg[ch] - 8'd1;
                    end
                    else
                    begin
                        hold_next[ch] = (hold_reg[ch] > decay_step_reg) ?
                                        (hold_reg[ch] - decay_step_reg) : '0;
                    end
                end
                base_next  = VAL_W'(({1'b0, sm_reg[0]} + {1'b0, sm_reg[1]}) >> 1);
                bar_next   = '0;
                state_next = ST_BAR_MUL1;
            end
            ST_BAR_MUL1:
            begin
                state_next = ST_BAR_MUL2;
            end
            ST_BAR_MUL2:
            begin
                up_next    = tgt_up;
                level_next = cur_level;
                state_next = ST_BAR_FIN;
            end
            ST_BAR_FIN:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    bar_valid_next[bar_reg] = 1'b1;
                    out_valid_next = 1'b1;
                    out_index_next = IDX_W'(bar_reg);
                    out_level_next = lv_new;
                    out_psl_next   = sm_reg[0];
                    out_psr_next   = sm_reg[1];
                    out_rsl_next   = sm_reg[2];
                    out_rsr_next   = sm_reg[3];
                    out_hl_next    = hold_reg[0];
                    out_hr_next    = hold_reg[1];
                    out_mean_next  = VAL_W'(({1'b0, sm_reg[2]} + {1'b0, sm_reg[3]}) >> 1);
                    out_last_next  = last_bar_now;
                    bar_next       = bar_reg + BAR_AW'(1);
                    state_next     = last_bar_now ? ST_IDLE : ST_BAR_MUL1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            bar_reg       <= '0;
            bar_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                sm_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                hold_reg[i] <= '0;
                hcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            bar_reg       <= bar_next;
            bar_valid_reg <= bar_valid_next;
            out_valid_reg <= out_valid_next;
            sm_reg        <= sm_next;
            hold_reg      <= hold_next;
            hcnt_reg      <= hcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        db_reg        <= db_next;
        lin_reg       <= lin_next;
        base_reg      <= base_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        up_reg        <= up_next;
        level_reg     <= level_next;
        out_index_reg <= out_index_next;
        out_level_reg <= out_level_next;
        out_psl_reg   <= out_psl_next;
        out_psr_reg   <= out_psr_next;
        out_rsl_reg   <= out_rsl_next;
        out_rsr_reg   <= out_rsr_next;
        out_hl_reg    <= out_hl_next;
        out_hr_reg    <= out_hr_next;
        out_mean_reg  <= out_mean_next;
        out_last_reg  <= out_last_next;
    end

    slm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NBARS)
    ) u_bar_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bar_reg),
        .wdata (lv_new),
        .raddr (bar_reg),
        .rdata (ram_rdata)
    );

    assign meter.valid             = out_valid_reg;
    assign meter.bar_index         = out_index_reg;
    assign meter.bar_level         = out_level_reg;
    assign meter.smooth_peak_left  = out_psl_reg;
    assign meter.smooth_peak_right = out_psr_reg;
    assign meter.smooth_rms_left   = out_rsl_reg;
    assign meter.smooth_rms_right  = out_rsr_reg;
    assign meter.hold_left         = out_hl_reg;
    assign meter.hold_right        = out_hr_reg;
    assign meter.mean_rms          = out_mean_reg;
    assign meter.last_bar          = out_last_reg;

endmodule

`default_nettype wire

// File: src/slm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
